// ===== rtl/indexed_insert_delete_array_top_assert.svh =====
// assertion macros shared by the array block
`ifndef INDEXED_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH
`define INDEXED_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH

// same-cycle check
`define IIDA_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("iida assertion failed");

// next-cycle check
`define IIDA_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("iida assertion failed");

`endif

// ===== rtl/iida_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iida_pkg
// Shared constants and codes for the indexed insert/delete array.
// ----------------------------------------------------------------------------
package iida_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    CMD_DUMP   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_EDIT   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_LOAD   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_BAD_IDX  = 3'd2,
    STAT_BAD_LOAD = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_LOAD  = 3'd1,
    CELL_LEFT  = 3'd2,
    CELL_RIGHT = 3'd3,
    CELL_HEAD  = 3'd4
  } cell_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

endpackage

// ===== rtl/iida_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iida_cell
// One array entry: holds, loads the input word, or takes a neighbor's or the head cell's word.
// ----------------------------------------------------------------------------
module iida_cell
  import iida_pkg::*;
(
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic signed [WORD_W-1:0] data_word,
  input  logic signed [WORD_W-1:0] left,
  input  logic signed [WORD_W-1:0] right,
  input  logic signed [WORD_W-1:0] head,
  output logic signed [WORD_W-1:0] value
);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD:  value <= value;
      CELL_LOAD:  value <= data_word;
      CELL_LEFT:  value <= left;
      CELL_RIGHT: value <= right;
      CELL_HEAD:  value <= head;
      default:    value <= value;
    endcase
  end

endmodule

// ===== rtl/indexed_insert_delete_array_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_top
// Ordered array of signed words kept in a row of cells, with a fill count.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  cmd     | cmd_valid, cmd_ready  | command, position, data_word, load_total
//  res     | res_valid, res_ready  | element_value, element_index, status,
//          |                       | last_result, fill_count
//
//  insert, edit, delete and load update all cells in parallel; insert and delete shift them
//  a dump of n elements gives n results; the cells rotate through the
//  head cell once per result, so the array is back in place at the end
//  cmd_ready is low during a dump and while the result register is held
//  rst clears the count and control; cell contents are undefined until written
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_top
  import iida_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  logic [2:0]               command,
  input  logic signed [6:0]        position,
  input  logic signed [WORD_W-1:0] data_word,
  input  logic [5:0]               load_total,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic signed [WORD_W-1:0] element_value,
  output logic [IDX_W-1:0]         element_index,
  output logic [2:0]               status,
  output logic                     last_result,
  output logic [CNT_W-1:0]         fill_count
);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [CNT_W-1:0]         k, k_next;
  logic                     slot_free, acc, dump_step, res_load;
  logic signed [WORD_W-1:0] r_value;
  logic [IDX_W-1:0]         r_index;
  status_t                  r_status;
  logic                     r_last;

  logic signed [WORD_W-1:0] cell_value [DEPTH];
  cell_op_t                 cell_op [DEPTH];

  logic                     pos_neg, pos_in_cnt, full;
  logic [5:0]               pos_u;
  logic [CNT_W-1:0]         ins_at, last_idx;
  logic                     load_bad_total, load_in, load_final;

  assign slot_free      = !res_valid || res_ready;
  assign acc            = cmd_valid && cmd_ready;
  assign pos_neg        = position[6];
  assign pos_u          = position[5:0];
  assign pos_in_cnt     = !pos_neg && (pos_u < {1'b0, count});
  assign full           = (count == CNT_W'(DEPTH));
  assign ins_at         = pos_neg ? '0 :
                          (pos_u > {1'b0, count}) ? count : pos_u[CNT_W-1:0];
  assign last_idx       = count - CNT_W'(1);
  assign load_bad_total = (load_total == 6'd0) || (load_total > 6'(DEPTH));
  assign load_in        = !pos_neg && (pos_u < load_total);
  assign load_final     = (pos_u == load_total - 6'd1);

  // per-cell shift control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (dump_step) begin
        if (CNT_W'(i) < last_idx) begin
          cell_op[i] = CELL_RIGHT;
        end else if (CNT_W'(i) == last_idx) begin
          cell_op[i] = CELL_HEAD;
        end
      end else if (acc) begin
        case (command)
          CMD_INSERT: begin
            if (!full) begin
              if (CNT_W'(i) == ins_at) begin
                cell_op[i] = CELL_LOAD;
              end else if (CNT_W'(i) > ins_at) begin
                cell_op[i] = CELL_LEFT;
              end
            end
          end
          CMD_EDIT: begin
            if (pos_in_cnt && (6'(i) == pos_u)) begin
              cell_op[i] = CELL_LOAD;
            end
          end
          CMD_DELETE: begin
            if (pos_in_cnt && (6'(i) >= pos_u)) begin
              cell_op[i] = CELL_RIGHT;
            end
          end
          CMD_LOAD: begin
            if (!load_bad_total && load_in && (6'(i) == pos_u)) begin
              cell_op[i] = CELL_LOAD;
            end
          end
          default: cell_op[i] = CELL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_value[g+1];
    end
    iida_cell u_cell (
      .clk       (clk),
      .op        (cell_op[g]),
      .data_word (data_word),
      .left      (left_w),
      .right     (right_w),
      .head      (cell_value[0]),
      .value     (cell_value[g])
    );
  end

  // control
  always_comb begin
    state_next = state;
    count_next = count;
    k_next     = k;
    cmd_ready  = 1'b0;
    dump_step  = 1'b0;
    res_load   = 1'b0;
    r_value    = '0;
    r_index    = '0;
    r_status   = STAT_OK;
    r_last     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = slot_free;
        if (acc) begin
          res_load = 1'b1;
          case (command)
            CMD_DUMP: begin
              if (count == '0) begin
                r_status = STAT_EMPTY;
              end else begin
                res_load   = 1'b0;
                k_next     = '0;
                state_next = ST_DUMP;
              end
            end
            CMD_INSERT: begin
              if (full) begin
                r_status = STAT_FULL;
              end else begin
                count_next = count + CNT_W'(1);
              end
            end
            CMD_EDIT: begin
              if (!pos_in_cnt) begin
                r_status = STAT_BAD_IDX;
              end
            end
            CMD_DELETE: begin
              if (!pos_in_cnt) begin
                r_status = STAT_BAD_IDX;
              end else begin
                count_next = count - CNT_W'(1);
              end
            end
            CMD_LOAD: begin
              if (load_bad_total) begin
                r_status = STAT_BAD_LOAD;
              end else if (!load_in) begin
                r_status = STAT_BAD_IDX;
              end else if (load_final) begin
                count_next = load_total[CNT_W-1:0];
              end
            end
            default: r_status = STAT_OK;
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          dump_step = 1'b1;
          res_load  = 1'b1;
          r_value   = cell_value[0];
          r_index   = k[IDX_W-1:0];
          r_last    = (k == last_idx);
          k_next    = k + CNT_W'(1);
          if (r_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      k         <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      k     <= k_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      element_value <= r_value;
      element_index <= r_index;
      status        <= r_status;
      last_result   <= r_last;
      fill_count    <= count_next;
    end
  end

`include "indexed_insert_delete_array_top_assert.svh"

  `IIDA_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_W'(DEPTH))
  `IIDA_ASSERT_NOW(a_dump_index, state == ST_DUMP, k < count)
  `IIDA_ASSERT_NEXT(a_dump_end, dump_step && r_last, state == ST_IDLE)
  `IIDA_ASSERT_NEXT(a_insert_grow, acc && (command == CMD_INSERT) && !full,
                    count == CNT_W'($past(count) + CNT_W'(1)))

endmodule
